### hdl/sxf_pkg.sv
`default_nettype none

package sxf_pkg;

  localparam int DIVIDEND_W = 8;
  localparam int REM_W      = 6;
  localparam int DIVISOR_W  = 7;
  localparam int TGT_W      = 7;
  localparam int PIX_W      = 64;

  typedef enum logic [1:0] {
    FUNC_DRAW  = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MODX,
    ST_MODY,
    ST_CHECK,
    ST_READ,
    ST_UPDATE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic                  sel_h;
  } rem_cmd_t;

  typedef struct packed {
    logic             done;
    logic [REM_W-1:0] rem;
  } rem_sts_t;

  typedef struct packed {
    logic clr;
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

### hdl/sxf_if.sv
`default_nettype none

interface sxf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] x_value;
  logic [7:0] y_value;
  logic [3:0] row_index;
  logic [7:0] sprite_byte;
  logic       last_row;

  modport source (output valid, func, x_value, y_value, row_index, sprite_byte, last_row,
                  input ready);
  modport sink (input valid, func, x_value, y_value, row_index, sprite_byte, last_row,
                output ready);
endinterface

interface sxf_out_if;
  logic        valid;
  logic        ready;
  logic        collision;
  logic        sprite_done;
  logic [63:0] row_pixels;

  modport source (output valid, collision, sprite_done, row_pixels, input ready);
  modport sink (input valid, collision, sprite_done, row_pixels, output ready);
endinterface

`default_nettype wire

### hdl/sxf_remunit.sv
`default_nettype none

module sxf_remunit import sxf_pkg::*; #(
  parameter int W = 64,
  parameter int H = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  rem_cmd_t cmd,
  output rem_sts_t sts
);

  // x mod n as x - n * floor(x * ceil(2^16 / n) / 2^16), exact for eight-bit x
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = 14;
  localparam int PROD_W      = DIVIDEND_W + RECIP_W;
  // divisor is at least eight, so the quotient fits five bits
  localparam int QUO_W       = 5;
  localparam int BACK_W      = QUO_W + DIVISOR_W;
  localparam logic [RECIP_W-1:0]   RECIP_X = RECIP_W'((2**RECIP_SHIFT + W - 1) / W);
  localparam logic [RECIP_W-1:0]   RECIP_Y = RECIP_W'((2**RECIP_SHIFT + H - 1) / H);
  localparam logic [DIVISOR_W-1:0] DIV_X   = DIVISOR_W'(W);
  localparam logic [DIVISOR_W-1:0] DIV_Y   = DIVISOR_W'(H);

  logic                  busy;
  logic                  phase;
  logic                  done;
  logic                  sel_h;
  logic [DIVIDEND_W-1:0] dvd;
  logic [QUO_W-1:0]      quo;
  logic [REM_W-1:0]      rem;
  logic [RECIP_W-1:0]    recip;
  logic [DIVISOR_W-1:0]  dsr;
  logic [PROD_W-1:0]     prod;
  logic [BACK_W-1:0]     back;
  logic [BACK_W-1:0]     diff;

  always_comb begin
    recip = sel_h ? RECIP_Y : RECIP_X;
    dsr   = sel_h ? DIV_Y : DIV_X;
    prod  = PROD_W'(dvd) * PROD_W'(recip);
    back  = BACK_W'(quo) * BACK_W'(dsr);
    diff  = BACK_W'(dvd) - back;
  end

  // while busy, the quotient is registered first and the remainder from it after
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        dvd   <= cmd.dividend;
        sel_h <= cmd.sel_h;
      end else if (busy) begin
        if (!phase) begin
          quo   <= prod[RECIP_SHIFT +: QUO_W];
          phase <= 1'b1;
        end else begin
          rem   <= diff[REM_W-1:0];
          phase <= 1'b0;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
  end

  assign sts.done = done;
  assign sts.rem  = rem;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (DIVISOR_W'(rem) < dsr)) else $error("remainder not below divisor");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without a running division");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done) else $error("busy and done together");

endmodule

`default_nettype wire

### hdl/sxf_rowmem.sv
`default_nettype none

module sxf_rowmem import sxf_pkg::*; #(
  parameter int W  = 64,
  parameter int H  = 32,
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] rd_addr,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [H];
  logic [H-1:0] valid;
  logic [W-1:0] rd_q;
  logic         rd_vld_q;

  // a row never written since reset or clear reads as all off
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.clr) begin
      valid <= '0;
    end else if (ctl.wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld_q <= 1'b0;
    end else if (ctl.rd_en) begin
      rd_vld_q <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign rd_data = rd_vld_q ? rd_q : '0;

  a_no_rd_wr: assert property (@(posedge clk) disable iff (rst)
    !(ctl.rd_en && ctl.wr_en)) else $error("read and write in one cycle");
  a_no_clr_wr: assert property (@(posedge clk) disable iff (rst)
    !(ctl.clr && (ctl.wr_en || ctl.rd_en))) else $error("clear overlaps access");
  a_wr_marks: assert property (@(posedge clk) disable iff (rst)
    ctl.wr_en |=> valid[$past(wr_addr)]) else $error("written row not marked");

endmodule

`default_nettype wire

### hdl/sprite_xor_framebuffer_core.sv
// one-bit-per-pixel framebuffer with row-at-a-time sprite xor draw
// in_ch takes one command word: draw one sprite row, clear screen, or read a row
// out_ch returns exactly one word per command: collision flag, sprite_done, row pixels
// the block takes one command at a time; in_ch.ready is high only when idle
// a draw runs both wraps, a range check, a row read and an update (a row below the
// screen stops at the check), a read the y wrap and a row read, clear and unused codes
// skip to the result; the next command is taken in the cycle after it is registered
// the x and y wrap runs on one shared two-step reciprocal remainder unit
// (x for a draw only); an on-screen row is then read and, for a draw, written back
// the row memory has one read and one write port; a row is one memory entry
// a finished word waits in the output register while out_ch.ready is low; the
// next command is taken meanwhile and its result waits at the end of its work
// until that register frees
// reset clears all pixels (per-row valid bits) and the collision flag at once,
// so no clearing pass is needed and a command may follow reset directly
// clear also works through the same valid bits, clearing them as the command is accepted
`default_nettype none

module sprite_xor_framebuffer_core import sxf_pkg::*; #(
  parameter int SCREEN_WIDTH  = 64,
  parameter int SCREEN_HEIGHT = 32
) (
  input  logic       clk,
  input  logic       rst,
  sxf_in_if.sink     in_ch,
  sxf_out_if.source  out_ch
);

  localparam int CW    = $clog2(SCREEN_WIDTH);
  localparam int AW    = $clog2(SCREEN_HEIGHT);
  localparam int EXT_W = SCREEN_WIDTH + 8;

  state_e state, state_next;

  logic [1:0]       func_q;
  logic [7:0]       y_q;
  logic [3:0]       ri_q;
  logic [7:0]       pat_q;
  logic             last_q;
  logic [CW-1:0]    col0;
  logic [REM_W-1:0] yrow;
  logic [AW-1:0]    row;
  logic             collision_flag;

  logic             out_valid;
  logic             out_collision;
  logic             out_done;
  logic [PIX_W-1:0] out_pixels;

  logic             accept;
  logic             load_out;
  logic [TGT_W-1:0] target;
  logic             in_range;
  logic [7:0]       rev;
  logic [EXT_W-1:0] ext;
  logic [SCREEN_WIDTH-1:0] mask;
  logic [SCREEN_WIDTH-1:0] rd_data;

  rem_cmd_t rem_cmd;
  rem_sts_t rem_sts;
  mem_ctl_t mem_ctl;

  sxf_remunit #(
    .W (SCREEN_WIDTH),
    .H (SCREEN_HEIGHT)
  ) u_rem (
    .clk (clk),
    .rst (rst),
    .cmd (rem_cmd),
    .sts (rem_sts)
  );

  sxf_rowmem #(
    .W  (SCREEN_WIDTH),
    .H  (SCREEN_HEIGHT),
    .AW (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mem_ctl),
    .rd_addr (row),
    .wr_addr (row),
    .wr_data (rd_data ^ mask),
    .rd_data (rd_data)
  );

  assign accept   = in_ch.valid && in_ch.ready;
  assign target   = TGT_W'(yrow) + TGT_W'(ri_q);
  assign in_range = target < TGT_W'(SCREEN_HEIGHT);

  // bit 7 of the pattern lands on the origin column; overflow past the edge drops
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      rev[b] = pat_q[7-b];
    end
    ext  = EXT_W'(rev) << col0;
    mask = ext[SCREEN_WIDTH-1:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.func)
            FUNC_DRAW: state_next = ST_MODX;
            FUNC_READ: state_next = ST_MODY;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_MODX: begin
        if (rem_sts.done) state_next = ST_MODY;
      end
      ST_MODY: begin
        if (rem_sts.done) state_next = (func_q == FUNC_DRAW) ? ST_CHECK : ST_READ;
      end
      ST_CHECK: begin
        state_next = in_range ? ST_READ : ST_DONE;
      end
      ST_READ: begin
        state_next = (func_q == FUNC_DRAW) ? ST_UPDATE : ST_DONE;
      end
      ST_UPDATE: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ch.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready      = 1'b0;
    load_out         = 1'b0;
    rem_cmd.start    = 1'b0;
    rem_cmd.dividend = y_q;
    rem_cmd.sel_h    = 1'b1;
    mem_ctl.clr      = 1'b0;
    mem_ctl.rd_en    = 1'b0;
    mem_ctl.wr_en    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.func == FUNC_DRAW) begin
          rem_cmd.start    = in_ch.valid;
          rem_cmd.dividend = in_ch.x_value;
          rem_cmd.sel_h    = 1'b0;
        end else if (in_ch.func == FUNC_READ) begin
          rem_cmd.start    = in_ch.valid;
          rem_cmd.dividend = in_ch.y_value;
        end else if (in_ch.func == FUNC_CLEAR) begin
          mem_ctl.clr = in_ch.valid;
        end
      end
      ST_MODX: begin
        rem_cmd.start = rem_sts.done;
      end
      ST_READ: begin
        mem_ctl.rd_en = 1'b1;
      end
      ST_UPDATE: begin
        mem_ctl.wr_en = 1'b1;
      end
      ST_DONE: begin
        load_out = !out_valid || out_ch.ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= in_ch.func;
      y_q    <= in_ch.y_value;
      ri_q   <= in_ch.row_index;
      pat_q  <= in_ch.sprite_byte;
      last_q <= in_ch.last_row;
    end
    if (state == ST_MODX && rem_sts.done) begin
      col0 <= rem_sts.rem[CW-1:0];
    end
    if (state == ST_MODY && rem_sts.done) begin
      yrow <= rem_sts.rem;
      row  <= rem_sts.rem[AW-1:0];
    end
    if (state == ST_CHECK) begin
      row <= target[AW-1:0];
    end
  end

  // flag restarts on row zero of a sprite, even when that row falls off screen
  always_ff @(posedge clk) begin
    if (rst) begin
      collision_flag <= 1'b0;
    end else if (accept && in_ch.func == FUNC_DRAW && in_ch.row_index == '0) begin
      collision_flag <= 1'b0;
    end else if (state == ST_UPDATE && (rd_data & mask) != '0) begin
      collision_flag <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_collision <= collision_flag;
      out_done      <= (func_q == FUNC_DRAW) ? last_q : 1'b0;
      out_pixels    <= (func_q == FUNC_READ) ? PIX_W'(rd_data) : '0;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.collision   = out_collision;
  assign out_ch.sprite_done = out_done;
  assign out_ch.row_pixels  = out_pixels;

  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_ctl.wr_en |-> (TGT_W'(row) < TGT_W'(SCREEN_HEIGHT)))
    else $error("row write outside screen");
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_clear_keeps_flag: assert property (@(posedge clk) disable iff (rst)
    (accept && in_ch.func == FUNC_CLEAR) |=> (collision_flag == $past(collision_flag)))
    else $error("clear changed collision flag");
  a_load_only_done: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (state == ST_IDLE && out_valid)) else $error("result not registered");

endmodule

`default_nettype wire
